// ----- rtl/ttg_pkg.sv -----
// Shared types, constants and helper functions for the trapezoid trajectory generator.
package ttg_pkg;

  localparam int unsigned DIV_W    = 38;
  localparam int unsigned DEN_W    = 10;
  localparam int unsigned RAD_W    = 64;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned DT_W     = 6;
  localparam int unsigned STIFF_W  = 22;
  localparam int unsigned DAMP_W   = 18;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned NUM_GAIN = 5;

  localparam logic [DT_W-1:0]  DT_MIN     = 6'd1;
  localparam logic [DT_W-1:0]  DT_MAX     = 6'd50;
  localparam logic [DEN_W-1:0] DEN_MS     = 10'd1000;
  localparam logic [DEN_W-1:0] DEN_SMOOTH = 10'd5;

  localparam longint KP_MILLI [NUM_GAIN] = '{5000, 10000, 15000, 25000, 40000};
  localparam longint KD_MILLI [NUM_GAIN] = '{500, 800, 1200, 2000, 3000};

  typedef enum logic [2:0] {
    REG_MAX_VEL    = 3'd0,
    REG_MAX_ACC    = 3'd1,
    REG_OFFSET     = 3'd2,
    REG_REVERSE    = 3'd3,
    REG_MODE       = 3'd4,
    REG_FIRST_STEP = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESTART,
    OP_STATIC,
    OP_CALC,
    OP_SNAP,
    OP_MUL,
    OP_ROOT,
    OP_VEL,
    OP_STEPNUM,
    OP_DIV,
    OP_POS,
    OP_SMNUM,
    OP_SMOOTH
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_ROOT,
    S_ROOT_WAIT,
    S_VEL,
    S_STEPNUM,
    S_STEP,
    S_STEP_WAIT,
    S_POS,
    S_SMNUM,
    S_SM,
    S_SM_WAIT,
    S_SMOOTH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [30:0]        max_vel;
    logic [30:0]        max_acc;
    logic signed [31:0] offset;
    logic               reverse;
    logic               mode;
    logic [DT_W-1:0]    first_step;
  } cfg_t;

  typedef struct packed {
    op_e  op;
    logic in_ready;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic static_mode;
    logic snap;
    logic busy;
  } status_t;

  function automatic longint fx_milli(longint milli, int frac);
    return ((milli <<< frac) + 64'sd500) / 64'sd1000;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] dir_apply(logic signed [31:0] v, logic rev);
    if (!rev) begin
      return v;
    end
    if (v == 32'sh8000_0000) begin
      return 32'sh7FFF_FFFF;
    end
    return -v;
  endfunction

endpackage

// ----- rtl/ttg_div.sv -----
// Division by the constant 1000 or 5 by reciprocal multiplication, one 13-bit slice per cycle.
module ttg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ttg_pkg::DIV_W-1:0]  num_i,
  input  logic [ttg_pkg::DEN_W-1:0]  den_i,
  output logic                       busy_o,
  output logic [ttg_pkg::DIV_W-1:0]  quo_o
);
  import ttg_pkg::*;

  localparam int unsigned CHUNK_W   = 13;
  localparam int unsigned NUM_CHUNK = 3;
  localparam int unsigned RECIP_W   = CHUNK_W * NUM_CHUNK;
  localparam int unsigned ACC_W     = DIV_W + CHUNK_W + 1;
  localparam int unsigned CNT_W     = $clog2(NUM_CHUNK + 1);

  localparam logic [RECIP_W-1:0] RECIP_MS     = 39'd281474976711;
  localparam logic [RECIP_W-1:0] RECIP_SMOOTH = 39'd439804651111;
  localparam int unsigned        SHIFT_MS     = 48 - CHUNK_W * (NUM_CHUNK - 1);
  localparam int unsigned        SHIFT_SMOOTH = 41 - CHUNK_W * (NUM_CHUNK - 1);

  logic [DIV_W-1:0]   num_q, num_d;
  logic [RECIP_W-1:0] recip_q, recip_d;
  logic               small_q, small_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ACC_W-1:0]   part;

  always_comb begin
    part    = ACC_W'(num_q) * ACC_W'(recip_q[CHUNK_W-1:0]);
    num_d   = num_q;
    recip_d = recip_q;
    small_d = small_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    if (start_i) begin
      num_d   = num_i;
      small_d = (den_i == DEN_SMOOTH);
      recip_d = small_d ? RECIP_SMOOTH : RECIP_MS;
      acc_d   = '0;
      cnt_d   = CNT_W'(NUM_CHUNK);
    end else if (cnt_q != '0) begin
      recip_d = recip_q >> CHUNK_W;
      acc_d   = (acc_q >> CHUNK_W) + part;
      cnt_d   = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    recip_q <= recip_d;
    small_q <= small_d;
    acc_q   <= acc_d;
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = small_q ? DIV_W'(acc_q >> SHIFT_SMOOTH) : DIV_W'(acc_q >> SHIFT_MS);

endmodule

// ----- rtl/ttg_sqrt.sv -----
// Integer square root, one root bit per cycle.
module ttg_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ttg_pkg::RAD_W-1:0]   rad_i,
  output logic                        busy_o,
  output logic [ttg_pkg::ROOT_W-1:0]  root_o
);
  import ttg_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REM_W+1:0]  cur;
  logic [REM_W+1:0]  trial;
  logic              fits;

  always_comb begin
    cur    = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
    trial  = {2'b00, root_q, 2'b01};
    fits   = cur >= trial;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W);
    end else if (cnt_q != '0) begin
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      rem_d  = fits ? REM_W'(cur - trial) : cur[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = cnt_q != '0;
  assign root_o = root_q;

endmodule

// ----- rtl/ttg_datapath.sv -----
// Profile state, arithmetic steps and result registers.
module ttg_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ttg_pkg::cmd_t                cmd_i,
  input  ttg_pkg::cfg_t                cfg_i,
  input  logic                         operation_i,
  input  logic [31:0]                  now_ms_i,
  input  logic signed [31:0]           target_position_i,
  input  logic signed [31:0]           target_velocity_i,
  input  logic signed [31:0]           feedforward_torque_i,
  input  logic [ttg_pkg::LEVEL_W-1:0]  gain_level_i,
  output ttg_pkg::status_t             status_o,
  output logic signed [31:0]           position_o,
  output logic signed [31:0]           velocity_o,
  output logic [ttg_pkg::STIFF_W-1:0]  stiffness_o,
  output logic [ttg_pkg::DAMP_W-1:0]   damping_o,
  output logic signed [31:0]           torque_o
);
  import ttg_pkg::*;

  localparam logic [32:0] SNAP_POS = 33'(fx_milli(5, FRAC_BITS));
  localparam logic [32:0] SNAP_VEL = 33'(fx_milli(10, FRAC_BITS));

  localparam logic [STIFF_W-1:0] KP_TAB [NUM_GAIN] = '{
    STIFF_W'(fx_milli(KP_MILLI[0], FRAC_BITS)), STIFF_W'(fx_milli(KP_MILLI[1], FRAC_BITS)),
    STIFF_W'(fx_milli(KP_MILLI[2], FRAC_BITS)), STIFF_W'(fx_milli(KP_MILLI[3], FRAC_BITS)),
    STIFF_W'(fx_milli(KP_MILLI[4], FRAC_BITS))};
  localparam logic [DAMP_W-1:0] KD_TAB [NUM_GAIN] = '{
    DAMP_W'(fx_milli(KD_MILLI[0], FRAC_BITS)), DAMP_W'(fx_milli(KD_MILLI[1], FRAC_BITS)),
    DAMP_W'(fx_milli(KD_MILLI[2], FRAC_BITS)), DAMP_W'(fx_milli(KD_MILLI[3], FRAC_BITS)),
    DAMP_W'(fx_milli(KD_MILLI[4], FRAC_BITS))};

  logic                restart_q;
  logic [31:0]         now_q;
  logic signed [31:0]  tgt_q, tvel_q, torque_q;
  logic [LEVEL_W-1:0]  lvl_q;

  logic signed [31:0]  pp_q, pv_q, sm_q;
  logic [31:0]         prev_q;
  logic                seen_q;

  logic [DT_W-1:0]     dt_q;
  logic [32:0]         abserr_q;
  logic                errle_q;
  logic                snap_q;
  logic [RAD_W-1:0]    prod_q;
  logic [DIV_W-1:0]    div_num_q;
  logic [DEN_W-1:0]    div_den_q;
  logic                div_neg_q;
  logic signed [31:0]  res_pos_q, res_vel_q;

  logic signed [32:0]  err;
  logic [32:0]         abserr;
  logic [31:0]         abspv;
  logic signed [31:0]  gap;
  logic [DT_W-1:0]     dt_seen, dt_first, dt_d;
  logic [31:0]         vdm;
  logic signed [32:0]  vd, pv_ext, dv_s, vel_up, vel_dn, pv_new;
  logic signed [32:0]  step_s, pp_sum, smn;
  logic signed [31:0]  absp;
  logic signed [34:0]  sm_sum;
  logic [34:0]         sm_abs;
  logic [36:0]         accdt;
  logic [37:0]         pvdt;
  logic [LEVEL_W-1:0]  gsel;

  logic                sqrt_busy, div_busy;
  logic [ROOT_W-1:0]   root;
  logic [DIV_W-1:0]    quo;
  logic                div_start;

  always_comb begin
    err    = $signed({tgt_q[31], tgt_q}) - $signed({pp_q[31], pp_q});
    abserr = err[32] ? 33'(-err) : 33'(err);
    abspv  = pv_q[31] ? 32'(-pv_q) : 32'(pv_q);

    gap = $signed(now_q - prev_q);
    if (gap < 32'sd1) begin
      dt_seen = DT_MIN;
    end else if (gap > 32'sd50) begin
      dt_seen = DT_MAX;
    end else begin
      dt_seen = gap[DT_W-1:0];
    end
    if (cfg_i.first_step < DT_MIN) begin
      dt_first = DT_MIN;
    end else if (cfg_i.first_step > DT_MAX) begin
      dt_first = DT_MAX;
    end else begin
      dt_first = cfg_i.first_step;
    end
    dt_d = seen_q ? dt_seen : dt_first;

    vdm    = (root < {1'b0, cfg_i.max_vel}) ? root : {1'b0, cfg_i.max_vel};
    vd     = errle_q ? -$signed({1'b0, vdm}) : $signed({1'b0, vdm});
    dv_s   = $signed({1'b0, quo[31:0]});
    pv_ext = $signed({pv_q[31], pv_q});
    vel_up = pv_ext + dv_s;
    vel_dn = pv_ext - dv_s;
    if (pv_ext < vd) begin
      pv_new = (vel_up > vd) ? vd : vel_up;
    end else if (pv_ext > vd) begin
      pv_new = (vel_dn < vd) ? vd : vel_dn;
    end else begin
      pv_new = pv_ext;
    end

    step_s = div_neg_q ? -$signed({1'b0, quo[31:0]}) : $signed({1'b0, quo[31:0]});
    pp_sum = $signed({pp_q[31], pp_q}) + step_s;
    absp   = sat32($signed({pp_q[31], pp_q}) + $signed({cfg_i.offset[31], cfg_i.offset}));
    sm_sum = $signed({{3{sm_q[31]}}, sm_q} <<< 2) + $signed({{3{absp[31]}}, absp});
    sm_abs = sm_sum[34] ? 35'(-sm_sum) : 35'(sm_sum);
    smn    = step_s;

    accdt  = 37'(cfg_i.max_acc) * 37'(dt_q);
    pvdt   = 38'(abspv) * 38'(dt_q);

    if (lvl_q >= 3'd1 && lvl_q <= 3'd5) begin
      gsel = lvl_q - 3'd1;
    end else begin
      gsel = 3'd2;
    end
  end

  assign div_start = (cmd_i.op == OP_ROOT) || (cmd_i.op == OP_DIV);

  ttg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_ROOT),
    .rad_i   ({prod_q[RAD_W-2:0], 1'b0}),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  ttg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= '0;
      pv_q   <= '0;
      sm_q   <= '0;
      prev_q <= '0;
      seen_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_RESTART: begin
          pp_q   <= '0;
          pv_q   <= '0;
          sm_q   <= '0;
          prev_q <= '0;
          seen_q <= 1'b0;
        end
        OP_CALC: begin
          prev_q <= now_q;
          seen_q <= 1'b1;
        end
        OP_SNAP: begin
          pp_q <= tgt_q;
          pv_q <= '0;
        end
        OP_VEL:    pv_q <= pv_new[31:0];
        OP_POS:    pp_q <= sat32(pp_sum);
        OP_SMOOTH: sm_q <= smn[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        restart_q <= operation_i;
        now_q     <= now_ms_i;
        tgt_q     <= target_position_i;
        tvel_q    <= target_velocity_i;
        torque_q  <= feedforward_torque_i;
        lvl_q     <= gain_level_i;
      end
      OP_STATIC: begin
        res_pos_q <= dir_apply(sat32($signed({tgt_q[31], tgt_q}) +
                                     $signed({cfg_i.offset[31], cfg_i.offset})), cfg_i.reverse);
        res_vel_q <= dir_apply(tvel_q, cfg_i.reverse);
      end
      OP_CALC: begin
        dt_q     <= dt_d;
        abserr_q <= abserr;
        errle_q  <= err[32] || (err == '0);
        snap_q   <= (abserr < SNAP_POS) && ({1'b0, abspv} < SNAP_VEL);
      end
      OP_MUL: begin
        prod_q    <= RAD_W'(cfg_i.max_acc) * RAD_W'(abserr_q);
        div_num_q <= DIV_W'(accdt) + DIV_W'(500);
        div_den_q <= DEN_MS;
        div_neg_q <= 1'b0;
      end
      OP_STEPNUM: begin
        div_num_q <= DIV_W'(pvdt) + DIV_W'(500);
        div_den_q <= DEN_MS;
        div_neg_q <= pv_q[31];
      end
      OP_SMNUM: begin
        div_num_q <= DIV_W'(sm_abs) + DIV_W'(2);
        div_den_q <= DEN_SMOOTH;
        div_neg_q <= sm_sum[34];
      end
      OP_SMOOTH: begin
        res_pos_q <= dir_apply(smn[31:0], cfg_i.reverse);
        res_vel_q <= dir_apply(pv_q, cfg_i.reverse);
      end
      default: begin
      end
    endcase
  end

  assign status_o.restart     = restart_q;
  assign status_o.static_mode = !cfg_i.mode;
  assign status_o.snap        = snap_q;
  assign status_o.busy        = sqrt_busy || div_busy;

  assign position_o  = res_pos_q;
  assign velocity_o  = res_vel_q;
  assign stiffness_o = KP_TAB[gsel];
  assign damping_o   = KD_TAB[gsel];
  assign torque_o    = dir_apply(torque_q, cfg_i.reverse);

endmodule

// ----- rtl/ttg_ctrl.sv -----
// Sequencer that steps the datapath through one request.
module ttg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  input  ttg_pkg::status_t  status_i,
  output ttg_pkg::cmd_t     cmd_o
);
  import ttg_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) begin
        state_d = S_DECODE;
      end
      S_DECODE: begin
        priority if (status_i.restart) begin
          state_d = S_IDLE;
        end else if (status_i.static_mode) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL:       state_d = status_i.snap ? S_SMNUM : S_ROOT;
      S_ROOT:      state_d = S_ROOT_WAIT;
      S_ROOT_WAIT: if (!status_i.busy) begin
        state_d = S_VEL;
      end
      S_VEL:       state_d = S_STEPNUM;
      S_STEPNUM:   state_d = S_STEP;
      S_STEP:      state_d = S_STEP_WAIT;
      S_STEP_WAIT: if (!status_i.busy) begin
        state_d = S_POS;
      end
      S_POS:       state_d = S_SMNUM;
      S_SMNUM:     state_d = S_SM;
      S_SM:        state_d = S_SM_WAIT;
      S_SM_WAIT:   if (!status_i.busy) begin
        state_d = S_SMOOTH;
      end
      S_SMOOTH:    state_d = S_DONE;
      S_DONE:      if (out_free_i) begin
        state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.in_ready = 1'b0;
    cmd_o.emit     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
        end
      end
      S_DECODE: begin
        priority if (status_i.restart) begin
          cmd_o.op = OP_RESTART;
        end else if (status_i.static_mode) begin
          cmd_o.op = OP_STATIC;
        end else begin
          cmd_o.op = OP_CALC;
        end
      end
      S_MUL:     cmd_o.op = status_i.snap ? OP_SNAP : OP_MUL;
      S_ROOT:    cmd_o.op = OP_ROOT;
      S_VEL:     cmd_o.op = OP_VEL;
      S_STEPNUM: cmd_o.op = OP_STEPNUM;
      S_STEP:    cmd_o.op = OP_DIV;
      S_POS:     cmd_o.op = OP_POS;
      S_SMNUM:   cmd_o.op = OP_SMNUM;
      S_SM:      cmd_o.op = OP_DIV;
      S_SMOOTH:  cmd_o.op = OP_SMOOTH;
      S_DONE:    cmd_o.emit = out_free_i;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/trapezoid_trajectory_generator_top.sv -----
// Top level: register port, sequencer, datapath and result register.
// A profile tick raises out_valid_o once the bit-serial square root and two more reciprocal
// divisions are done. A tick that snaps to the target skips the square root, a static tick
// skips all arithmetic, and a restart gives no result. One request is in work at a time;
// the next is taken while a result waits. Reset clears the profile state and loads the defaults.
module trapezoid_trajectory_generator_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttg_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic [31:0]                  now_ms_i,
  input  logic signed [31:0]           target_position_i,
  input  logic signed [31:0]           target_velocity_i,
  input  logic signed [31:0]           feedforward_torque_i,
  input  logic [ttg_pkg::LEVEL_W-1:0]  gain_level_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           position_command_o,
  output logic signed [31:0]           velocity_command_o,
  output logic [ttg_pkg::STIFF_W-1:0]  stiffness_gain_o,
  output logic [ttg_pkg::DAMP_W-1:0]   damping_gain_o,
  output logic signed [31:0]           torque_command_o
);
  import ttg_pkg::*;

  cfg_t     cfg_q;
  cmd_t     cmd;
  status_t  status;
  reg_idx_e idx;
  logic     wr_en;
  logic     out_free;

  logic signed [31:0]  dp_pos, dp_vel, dp_torque;
  logic [STIFF_W-1:0]  dp_kp;
  logic [DAMP_W-1:0]   dp_kd;

  logic                out_valid_q;
  logic signed [31:0]  pos_q, vel_q, torque_q;
  logic [STIFF_W-1:0]  kp_q;
  logic [DAMP_W-1:0]   kd_q;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_vel    <= 31'd131072;
      cfg_q.max_acc    <= 31'd327680;
      cfg_q.offset     <= '0;
      cfg_q.reverse    <= 1'b0;
      cfg_q.mode       <= 1'b1;
      cfg_q.first_step <= 6'd1;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_VEL:    cfg_q.max_vel    <= pwdata[30:0];
        REG_MAX_ACC:    cfg_q.max_acc    <= pwdata[30:0];
        REG_OFFSET:     cfg_q.offset     <= pwdata;
        REG_REVERSE:    cfg_q.reverse    <= pwdata[0];
        REG_MODE:       cfg_q.mode       <= pwdata[0];
        REG_FIRST_STEP: cfg_q.first_step <= pwdata[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_VEL:    prdata = {1'b0, cfg_q.max_vel};
      REG_MAX_ACC:    prdata = {1'b0, cfg_q.max_acc};
      REG_OFFSET:     prdata = cfg_q.offset;
      REG_REVERSE:    prdata = {31'd0, cfg_q.reverse};
      REG_MODE:       prdata = {31'd0, cfg_q.mode};
      REG_FIRST_STEP: prdata = {26'd0, cfg_q.first_step};
      default:        prdata = '0;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  ttg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttg_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_i                (cfg_q),
    .operation_i          (operation_i),
    .now_ms_i             (now_ms_i),
    .target_position_i    (target_position_i),
    .target_velocity_i    (target_velocity_i),
    .feedforward_torque_i (feedforward_torque_i),
    .gain_level_i         (gain_level_i),
    .status_o             (status),
    .position_o           (dp_pos),
    .velocity_o           (dp_vel),
    .stiffness_o          (dp_kp),
    .damping_o            (dp_kd),
    .torque_o             (dp_torque)
  );

  assign in_ready_o = cmd.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      pos_q    <= dp_pos;
      vel_q    <= dp_vel;
      kp_q     <= dp_kp;
      kd_q     <= dp_kd;
      torque_q <= dp_torque;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign position_command_o = pos_q;
  assign velocity_command_o = vel_q;
  assign stiffness_gain_o   = kp_q;
  assign damping_gain_o     = kd_q;
  assign torque_command_o   = torque_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending result");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in work");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd.emit))
    else $error("result appeared without an emit");

endmodule

// ----- tb/trapezoid_trajectory_generator_top_tb.sv -----
// Self-checking testbench for the trapezoid trajectory generator top level.
`timescale 1ns / 1ps

module trapezoid_trajectory_generator_top_tb;
  import ttg_pkg::*;

  localparam int         FRAC = 16;
  localparam longint     SNAP_POS = ((64'sd5 <<< FRAC) + 500) / 1000;
  localparam longint     SNAP_VEL = ((64'sd10 <<< FRAC) + 500) / 1000;
  localparam longint     S32_HI = 64'sd2147483647;
  localparam longint     S32_LO = -64'sd2147483648;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         SETTLE = 200;
  localparam logic       OP_TICK = 1'b0;
  localparam logic       OP_CLEAR = 1'b1;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic [STIFF_W-1:0] kp;
    logic [DAMP_W-1:0]  kd;
    logic signed [31:0] tq;
  } command_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = 1'b0;
  logic [31:0] now_ms_i = '0;
  logic signed [31:0] target_position_i = '0;
  logic signed [31:0] target_velocity_i = '0;
  logic signed [31:0] feedforward_torque_i = '0;
  logic [LEVEL_W-1:0] gain_level_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] position_command_o, velocity_command_o, torque_command_o;
  logic [STIFF_W-1:0] stiffness_gain_o;
  logic [DAMP_W-1:0] damping_gain_o;

  trapezoid_trajectory_generator_top u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state and register copy
  longint unsigned lim_vel, lim_acc;
  longint zero_offset;
  bit reversed, profiling;
  int unsigned first_dt;
  longint prof_pos, prof_vel, smooth_pos;
  logic [31:0] last_ms;
  bit seen_tick;

  command_t pending_commands[$];
  int errors = 0, checked = 0, ticks = 0, clears = 0, snaps = 0;
  int cycles = 0;
  bit quiet = 0, hold_req = 0;
  logic [31:0] ms_clock = '0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_commands.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint clamp32(longint v);
    return v > S32_HI ? S32_HI : (v < S32_LO ? S32_LO : v);
  endfunction

  function automatic longint flip(longint v);
    return reversed ? clamp32(-v) : v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint m;
    m = (mag(num) + den / 2) / den;
    return num < 0 ? -m : m;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint milli_fx(longint m);
    return ((m <<< FRAC) + 500) / 1000;
  endfunction

  task automatic predict_command(logic op, logic [31:0] now, logic signed [31:0] tp,
                                 logic signed [31:0] tv, logic signed [31:0] tq,
                                 logic [2:0] lvl);
    longint dt, err, vd, dv, absp, p_out, v_out;
    longint unsigned vb;
    logic signed [31:0] gap;
    int g;
    longint kp_m[5] = '{5000, 10000, 15000, 25000, 40000};
    longint kd_m[5] = '{500, 800, 1200, 2000, 3000};
    command_t c;
    if (op == OP_CLEAR) begin
      prof_pos = 0;
      prof_vel = 0;
      smooth_pos = 0;
      last_ms = '0;
      seen_tick = 0;
      clears++;
      return;
    end
    ticks++;
    if (profiling) begin
      gap = now - last_ms;
      dt = seen_tick ? longint'(gap) : longint'(first_dt);
      if (dt < 1) dt = 1;
      if (dt > 50) dt = 50;
      last_ms = now;
      seen_tick = 1;
      err = longint'(tp) - prof_pos;
      if (mag(err) < SNAP_POS && mag(prof_vel) < SNAP_VEL) begin
        prof_pos = tp;
        prof_vel = 0;
        snaps++;
      end else begin
        vb = floor_root(2 * lim_acc * longint'(mag(err)));
        vd = longint'(vb < lim_vel ? vb : lim_vel);
        if (err <= 0) vd = -vd;
        dv = (longint'(lim_acc) * dt + 500) / 1000;
        if (prof_vel < vd) begin
          prof_vel += dv;
          if (prof_vel > vd) prof_vel = vd;
        end else if (prof_vel > vd) begin
          prof_vel -= dv;
          if (prof_vel < vd) prof_vel = vd;
        end
        prof_pos = clamp32(prof_pos + round_div(prof_vel * dt, 1000));
      end
      absp = clamp32(prof_pos + zero_offset);
      smooth_pos = round_div(4 * smooth_pos + absp, 5);
      p_out = flip(smooth_pos);
      v_out = flip(prof_vel);
    end else begin
      p_out = flip(clamp32(longint'(tp) + zero_offset));
      v_out = flip(tv);
    end
    g = (lvl >= 1 && lvl <= 5) ? lvl - 1 : 2;
    c.pos = p_out[31:0];
    c.vel = v_out[31:0];
    c.kp = STIFF_W'(milli_fx(kp_m[g]));
    c.kd = DAMP_W'(milli_fx(kd_m[g]));
    c.tq = 32'(flip(tq));
    pending_commands.push_back(c);
  endtask

  // Receiver: random ready bursts, or a long hold-off on request
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end else if (quiet || $urandom_range(0, 1)) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
    end
  endtask

  always @(negedge clk_i) begin
    command_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_commands.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual pos %h", $time,
                 position_command_o);
      end else begin
        e = pending_commands.pop_front();
        checked++;
        check_field("position", e.pos, position_command_o);
        check_field("velocity", e.vel, velocity_command_o);
        check_field("stiffness", 32'(e.kp), 32'(stiffness_gain_o));
        check_field("damping", 32'(e.kd), 32'(damping_gain_o));
        check_field("torque", e.tq, torque_command_o);
      end
    end
  end

  task automatic send_request(logic op, logic [31:0] now, logic signed [31:0] tp,
                              logic signed [31:0] tv, logic signed [31:0] tq,
                              logic [2:0] lvl);
    in_valid_i <= 1'b1;
    operation_i <= op;
    now_ms_i <= now;
    target_position_i <= tp;
    target_velocity_i <= tv;
    feedforward_torque_i <= tq;
    gain_level_i <= lvl;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predict_command(op, now, tp, tv, tq, lvl);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic tick(logic signed [31:0] tp, int unsigned adv);
    ms_clock += adv;
    send_request(OP_TICK, ms_clock, tp, $urandom, $urandom, 3'($urandom_range(0, 7)));
  endtask

  task automatic wait_idle();
    if (in_valid_i) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
    end
    while (pending_commands.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_VEL:    lim_vel = 64'(v[30:0]);
      REG_MAX_ACC:    lim_acc = 64'(v[30:0]);
      REG_OFFSET:     zero_offset = longint'($signed(v));
      REG_REVERSE:    reversed = v[0];
      REG_MODE:       profiling = v[0];
      REG_FIRST_STEP: first_dt = 32'(v[5:0]);
      default: ;
    endcase
  endtask

  task automatic test_defaults();
    repeat (6) tick(32'sh0001_0000, 1);
    tick(32'sh0001_0000, 0);
  endtask

  task automatic test_directed();
    send_request(OP_TICK, 32'hFFFF_FFF0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh8000_0000, 3'd0);
    send_request(OP_TICK, 32'h0000_0010, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 3'd7);
    send_request(OP_TICK, 32'h0000_0005, 32'sh8000_0000, 0, 0, 3'd6);
    send_request(OP_TICK, 32'h0000_1000, 32'sh0000_0000, 0, 0, 3'd1);
    send_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, 3'd2);
    ms_clock = 32'h0000_0100;
    write_reg(REG_FIRST_STEP, 32'd50);
    write_reg(REG_MAX_ACC, 32'h7FFF_FFFF);
    write_reg(REG_MAX_VEL, 32'h7FFF_FFFF);
    tick(32'sh7FFF_FFFF, 0);
    tick(32'sh8000_0000, 50);
    send_request(OP_CLEAR, 0, 0, 0, 0, 3'd0);
    tick(32'sh0000_0100, 3);
    tick(32'sh0000_0000, 3);
    tick(32'sh0000_0000, 3);
    write_reg(REG_REVERSE, 32'd1);
    write_reg(REG_OFFSET, 32'h8000_0000);
    send_request(OP_TICK, ms_clock, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 3'd2);
    write_reg(REG_OFFSET, 32'h7FFF_FFFF);
    write_reg(REG_MAX_VEL, 32'd0);
    write_reg(REG_MAX_ACC, 32'd0);
    write_reg(REG_FIRST_STEP, 32'd0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 3'd0);
    tick(32'sh7FFF_FFFF, 1);
    tick(32'sh1000_0000, 1);
    write_reg(REG_MODE, 32'd0);
    for (int l = 0; l < 8; l++) tick(32'sh7FFF_FFFF, 1);
    write_reg(REG_REVERSE, 32'd0);
    write_reg(REG_OFFSET, 32'd0);
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_FIRST_STEP, 32'd63);
    write_reg(REG_MAX_VEL, 32'd131072);
    write_reg(REG_MAX_ACC, 32'd327680);
    send_request(OP_CLEAR, 0, 0, 0, 0, 3'd0);
    tick(32'sh0000_0040, 1);
  endtask

  task automatic random_config();
    write_reg(REG_MAX_VEL, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1 << 14, 1 << 21));
    write_reg(REG_MAX_ACC, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1 << 16, 1 << 25));
    write_reg(REG_OFFSET, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 18));
    write_reg(REG_REVERSE, $urandom_range(0, 1));
    write_reg(REG_MODE, 32'($urandom_range(0, 5) != 0));
    write_reg(REG_FIRST_STEP, $urandom_range(0, 63));
  endtask

  task automatic random_segment(int n);
    logic signed [31:0] goal;
    int unsigned adv;
    for (int k = 0; k < n; k++) begin
      if (k % 30 == 0) begin
        goal = ($urandom_range(0, 7) == 0) ? $urandom :
               32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      end
      case ($urandom_range(0, 19))
        0: send_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, 3'($urandom));
        1: send_request(OP_TICK, $urandom, $urandom, $urandom, $urandom, 3'($urandom));
        2: begin
          adv = $urandom;
          tick(goal, adv);
        end
        default: begin
          adv = $urandom_range(0, 60);
          tick(goal, adv);
        end
      endcase
    end
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      random_segment(100);
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_MODE, 32'd1);
    hold_req = 1;
    random_segment(30);
  endtask

  task automatic test_steady_stream();
    wait_idle();
    quiet = 1;
    random_segment(100);
  endtask

  initial begin
    lim_vel = 131072;
    lim_acc = 327680;
    zero_offset = 0;
    reversed = 0;
    profiling = 1;
    first_dt = 1;
    prof_pos = 0;
    prof_vel = 0;
    smooth_pos = 0;
    last_ms = '0;
    seen_tick = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_directed();
    test_random_phases();
    test_backpressure();
    test_steady_stream();
    wait_idle();
    $display("Covered %0d ticks and %0d restarts; %0d results checked, %0d snaps to target.",
             ticks, clears, checked, snaps);
    if (errors == 0 && pending_commands.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ttg_pkg.sv
rtl/ttg_div.sv
rtl/ttg_sqrt.sv
rtl/ttg_datapath.sv
rtl/ttg_ctrl.sv
rtl/trapezoid_trajectory_generator_top.sv
tb/trapezoid_trajectory_generator_top_tb.sv
